// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: %m");
// An implication: when the antecedent holds, the consequent holds too.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg
// Types, codes and the sequencer program of the box/frustum cull block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int COEF_W     = 16;
    localparam int FIELD_W    = 16;
    localparam int PLANE_W    = 64;
    localparam int APB_DATA_W = 64;
    localparam int PADDR_W    = 6;

    // Bit positions inside mode_flags.
    localparam int MODE_MASKING = 0;
    localparam int MODE_COHERENT = 1;
    localparam int MODE_CONSERV = 2;

    typedef enum logic [2:0] {
        REG_PLANE_0     = 3'd0,
        REG_PLANE_1     = 3'd1,
        REG_PLANE_2     = 3'd2,
        REG_PLANE_3     = 3'd3,
        REG_PLANE_4     = 3'd4,
        REG_PLANE_5     = 3'd5,
        REG_PLANE_COUNT = 3'd6,
        REG_MODE_FLAGS  = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        CONT_OUTSIDE   = 2'd0,
        CONT_INSIDE    = 2'd1,
        CONT_INTERSECT = 2'd2
    } t_containment;

    typedef struct packed {
        logic signed [FIELD_W-1:0] min_x;
        logic signed [FIELD_W-1:0] min_y;
        logic signed [FIELD_W-1:0] min_z;
        logic signed [FIELD_W-1:0] max_x;
        logic signed [FIELD_W-1:0] max_y;
        logic signed [FIELD_W-1:0] max_z;
        logic [2:0]                first_plane;
        logic [5:0]                plane_mask_in;
        logic                      track_first;
        logic                      track_mask;
    } t_in_item;

    typedef struct packed {
        logic [1:0] containment;
        logic [2:0] fail_plane_out;
        logic [5:0] plane_mask_out;
    } t_out_item;

    // Control from the sequencer to the plane datapath.
    typedef struct packed {
        logic load;
        logic cons;
    } t_eval_ctl;

    typedef logic [2:0] t_step;

    localparam t_step STEP_IDLE  = 3'd0;
    localparam t_step STEP_CHECK = 3'd1;
    localparam t_step STEP_SKIP  = 3'd2;
    localparam t_step STEP_MUL   = 3'd3;
    localparam t_step STEP_EVAL  = 3'd4;
    localparam t_step STEP_ADV   = 3'd5;
    localparam t_step STEP_SPARE = 3'd6;
    localparam t_step STEP_FIN   = 3'd7;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_DONE,
        C_SKIP,
        C_OUT,
        C_OBUSY
    } t_cond;

    // One control word: actions for this step, then jump to target when the
    // condition holds, else go on to the next step (wrapping to the start).
    typedef struct packed {
        logic  accept;
        logic  ld_mul;
        logic  eval;
        logic  adv;
        logic  finish;
        t_cond cond;
        t_step target;
    } t_ucode;

    function automatic t_ucode ucode_rom(input t_step step);
        t_ucode w;
        w = '0;
        w.cond = C_NEVER;
        w.target = STEP_IDLE;
        case (step)
            STEP_IDLE: begin
                w.accept = 1'b1;
                w.cond = C_NO_IN;
                w.target = STEP_IDLE;
            end
            STEP_CHECK: begin
                w.cond = C_DONE;
                w.target = STEP_FIN;
            end
            STEP_SKIP: begin
                w.cond = C_SKIP;
                w.target = STEP_ADV;
            end
            STEP_MUL: begin
                w.ld_mul = 1'b1;
            end
            STEP_EVAL: begin
                w.eval = 1'b1;
                w.cond = C_OUT;
                w.target = STEP_FIN;
            end
            STEP_ADV: begin
                w.adv = 1'b1;
                w.cond = C_ALWAYS;
                w.target = STEP_CHECK;
            end
            STEP_FIN: begin
                w.finish = 1'b1;
                w.cond = C_OBUSY;
                w.target = STEP_FIN;
            end
            default: begin
                w.cond = C_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // Starting plane of the coherent rotation: first modulo the plane count.
    function automatic logic [2:0] start_plane(input logic [2:0] first, input logic [2:0] n);
        logic [2:0] r;
        r = first;
        if (n != 3'd0) begin
            for (int k = 0; k < 7; k++) begin
                if (r >= n) begin
                    r = r - n;
                end
            end
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bfc_plane_eval.sv
// ----------------------------------------------------------------------------
// bfc_plane_eval
// Multiplies one plane against the box extents, then classifies the box.
// ----------------------------------------------------------------------------
`default_nettype none

module bfc_plane_eval
    import bfc_pkg::*;
#(
    parameter int XW  = 16,
    parameter int NFB = 14
) (
    input  wire logic               i_clk,
    input  wire t_eval_ctl          i_ctl,
    input  wire logic [PLANE_W-1:0] i_plane,
    input  wire logic signed [XW-1:0] i_lo [3],
    input  wire logic signed [XW-1:0] i_hi [3],
    output t_containment            o_class
);

    localparam int PW = COEF_W + XW;
    localparam int SW = PW + 2;

    logic signed [COEF_W-1:0] coef [4];
    logic signed [PW-1:0]     r_plo [3];
    logic signed [PW-1:0]     r_phi [3];
    logic signed [SW-1:0]     r_dterm;
    logic [2:0]               r_pos;
    logic                     r_cons;
    logic signed [SW-1:0]     corner_sum [8];
    logic [7:0]               c_in;
    logic [7:0]               c_out;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            coef[k] = i_plane[COEF_W*k +: COEF_W];
        end
    end

    // The far corner takes the max on each axis whose coefficient is positive.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int j = 0; j < 3; j++) begin
                r_plo[j] <= coef[j] * i_lo[j];
                r_phi[j] <= coef[j] * i_hi[j];
            end
            r_dterm <= SW'(coef[3]) <<< NFB;
            r_pos <= {!coef[0][COEF_W-1] && (coef[0] != '0),
                      !coef[1][COEF_W-1] && (coef[1] != '0),
                      !coef[2][COEF_W-1] && (coef[2] != '0)};
            r_cons <= i_ctl.cons;
        end
    end

    always_comb begin
        logic [2:0] kk;
        kk = 3'd0;
        for (int k = 0; k < 8; k++) begin
            kk = 3'(k);
            corner_sum[k] = SW'(kk[2] ? r_phi[0] : r_plo[0])
                          + SW'(kk[1] ? r_phi[1] : r_plo[1])
                          + SW'(kk[0] ? r_phi[2] : r_plo[2])
                          + r_dterm;
            c_out[k] = corner_sum[k][SW-1];
            c_in[k]  = !corner_sum[k][SW-1] && (corner_sum[k] != '0);
        end
    end

    always_comb begin
        if (r_cons) begin
            if (c_in[~r_pos]) begin
                o_class = CONT_INSIDE;
            end else if (c_out[r_pos]) begin
                o_class = CONT_OUTSIDE;
            end else begin
                o_class = CONT_INTERSECT;
            end
        end else begin
            // A box with no corner strictly inside counts as outside.
            if (c_in == 8'd0) begin
                o_class = CONT_OUTSIDE;
            end else if (c_out == 8'd0) begin
                o_class = CONT_INSIDE;
            end else begin
                o_class = CONT_INTERSECT;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/box_frustum_cull.sv
// ----------------------------------------------------------------------------
// box_frustum_cull
// Classifies a box against up to six planes, microcoded one plane at a time.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  in        input      i_in_valid/o_in_ready   i_in_data  (t_in_item)
//  out       output     o_out_valid/i_out_ready o_out_data (t_out_item)
//  cfg       input      APB psel/penable/pwrite paddr, pwdata, prdata
//
// One box steps through check, skip, multiply, classify and advance per plane,
// a masked plane going from skip straight to advance; an outside plane ends
// the run right after its classify step. Each plane has a single multiply stage.
// A new box beat is taken only when the sequencer is back at its idle step;
// the finished result waits in the output register meanwhile.
// Reset is synchronous and active low; plane memory reads as zero until written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module box_frustum_cull
    import bfc_pkg::*;
#(
    parameter int COORD_BITS       = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int XW = (COORD_BITS > 16) ? 17 : 16;
    localparam int SB = (COORD_BITS > 16) ? 16 : COORD_BITS - 1;

    // Sign extend from COORD_BITS; wider settings leave the field positive.
    function automatic logic signed [XW-1:0] to_coord(input logic [FIELD_W-1:0] f);
        logic [FIELD_W:0] fe;
        logic [XW-1:0]    v;
        fe = {1'b0, f};
        v = '0;
        for (int k = 0; k < XW; k++) begin
            if (k < COORD_BITS) begin
                v[k] = fe[k];
            end else begin
                v[k] = fe[SB];
            end
        end
        return v;
    endfunction

    // Configuration storage
    logic [PLANE_W-1:0]    r_plane_mem [NUM_PLANES];
    logic [NUM_PLANES-1:0] r_plane_vld;
    logic [2:0]            r_plane_count;
    logic [2:0]            r_mode_flags;
    logic [PLANE_W-1:0]    r_plane_q;
    logic [APB_DATA_W-1:0] r_prdata;
    t_reg_idx              cfg_idx;
    logic                  cfg_wr;

    // Sequencer and item state
    t_step                 r_step;
    t_step                 n_step;
    t_ucode                cw;
    logic                  cond_hit;
    logic                  in_fire;
    logic                  out_free;
    logic [2:0]            n_planes;
    logic [2:0]            r_i;
    logic [2:0]            r_pl;
    logic                  r_cut;
    logic                  r_is_out;
    logic [2:0]            r_fail;
    logic [5:0]            r_mask;
    logic                  r_track_first;
    logic                  r_track_mask;
    logic signed [XW-1:0]  r_lo [3];
    logic signed [XW-1:0]  r_hi [3];
    logic                  r_out_valid;
    t_out_item             r_out;
    t_containment          eval_class;
    t_eval_ctl             eval_ctl;

    assign cfg_idx = t_reg_idx'(paddr[PADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = r_prdata;

    always_ff @(posedge i_clk) begin
        if (cfg_wr && (cfg_idx != REG_PLANE_COUNT) && (cfg_idx != REG_MODE_FLAGS)) begin
            r_plane_mem[3'(cfg_idx)] <= pwdata;
        end
        r_plane_q <= r_plane_vld[r_pl] ? r_plane_mem[r_pl] : '0;
        case (cfg_idx)
            REG_PLANE_COUNT: r_prdata <= APB_DATA_W'(r_plane_count);
            REG_MODE_FLAGS:  r_prdata <= APB_DATA_W'(r_mode_flags);
            default: begin
                r_prdata <= r_plane_vld[3'(cfg_idx)] ? r_plane_mem[3'(cfg_idx)] : '0;
            end
        endcase
    end

    // Sequencer
    assign cw         = ucode_rom(r_step);
    assign o_in_ready = cw.accept;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign n_planes   = (r_plane_count > 3'(NUM_PLANES)) ? 3'(NUM_PLANES) : r_plane_count;

    always_comb begin
        case (cw.cond)
            C_NEVER:  cond_hit = 1'b0;
            C_ALWAYS: cond_hit = 1'b1;
            C_NO_IN:  cond_hit = !in_fire;
            C_DONE:   cond_hit = (r_i >= n_planes);
            C_SKIP:   cond_hit = r_track_mask && r_mode_flags[MODE_MASKING] && !r_mask[r_pl];
            C_OUT:    cond_hit = (eval_class == CONT_OUTSIDE);
            C_OBUSY:  cond_hit = !out_free;
            default:  cond_hit = 1'b0;
        endcase
        n_step = cond_hit ? cw.target : r_step + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_vld   <= '0;
            r_plane_count <= 3'(NUM_PLANES);
            r_mode_flags  <= 3'd0;
            r_step        <= STEP_IDLE;
            r_i           <= 3'd0;
            r_pl          <= 3'd0;
            r_cut         <= 1'b0;
            r_is_out      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_PLANE_COUNT: r_plane_count <= pwdata[2:0];
                    REG_MODE_FLAGS:  r_mode_flags <= pwdata[2:0];
                    default:         r_plane_vld[3'(cfg_idx)] <= 1'b1;
                endcase
            end
            r_step <= n_step;
            if (in_fire) begin
                r_i      <= 3'd0;
                r_pl     <= (r_mode_flags[MODE_COHERENT] && i_in_data.track_first)
                          ? start_plane(i_in_data.first_plane, n_planes) : 3'd0;
                r_cut    <= 1'b0;
                r_is_out <= 1'b0;
            end
            if (cw.eval) begin
                if (eval_class == CONT_OUTSIDE) begin
                    r_is_out <= 1'b1;
                end else if (eval_class == CONT_INTERSECT) begin
                    r_cut <= 1'b1;
                end
            end
            if (cw.adv) begin
                r_i  <= r_i + 3'd1;
                r_pl <= (r_pl == n_planes - 3'd1) ? 3'd0 : r_pl + 3'd1;
            end
            if (cw.finish && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_lo[0]       <= to_coord(i_in_data.min_x);
            r_lo[1]       <= to_coord(i_in_data.min_y);
            r_lo[2]       <= to_coord(i_in_data.min_z);
            r_hi[0]       <= to_coord(i_in_data.max_x);
            r_hi[1]       <= to_coord(i_in_data.max_y);
            r_hi[2]       <= to_coord(i_in_data.max_z);
            r_fail        <= i_in_data.first_plane;
            r_mask        <= i_in_data.plane_mask_in;
            r_track_first <= i_in_data.track_first;
            r_track_mask  <= i_in_data.track_mask;
        end
        if (cw.eval) begin
            if (eval_class == CONT_OUTSIDE && r_track_first) begin
                r_fail <= r_pl;
            end else if (eval_class == CONT_INSIDE && r_track_mask) begin
                // Cleared even when masking is off, and kept on an early exit.
                r_mask[r_pl] <= 1'b0;
            end
        end
        if (cw.finish && out_free) begin
            r_out.containment    <= r_is_out ? CONT_OUTSIDE
                                  : (r_cut ? CONT_INTERSECT : CONT_INSIDE);
            r_out.fail_plane_out <= r_fail;
            r_out.plane_mask_out <= r_mask;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign eval_ctl.load = cw.ld_mul;
    assign eval_ctl.cons = r_mode_flags[MODE_CONSERV];

    bfc_plane_eval #(
        .XW  (XW),
        .NFB (NORMAL_FRAC_BITS)
    ) u_eval (
        .i_clk   (i_clk),
        .i_ctl   (eval_ctl),
        .i_plane (r_plane_q),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .o_class (eval_class)
    );

    `ASSERT_PROP(a_count_bound, i_clk, i_rst_n, r_i <= 3'(NUM_PLANES))
    `ASSERT_IMPL(a_plane_in_range, i_clk, i_rst_n, r_step == STEP_MUL, r_pl < n_planes)
    `ASSERT_IMPL(a_start_check, i_clk, i_rst_n, in_fire, ##1 (r_step == STEP_CHECK))
    `ASSERT_IMPL(a_result_loaded, i_clk, i_rst_n, cw.finish && out_free, ##1 o_out_valid)

endmodule

`default_nettype wire
